// File: rtl/ihex_pkg.sv
// Shared types, codes and a helper function for the HEX record decoder.
package ihex_pkg;

   localparam int CharWidth  = 8;
   localparam int CountWidth = 16;

   localparam logic       OP_CHAR = 1'b0;
   localparam logic       OP_END  = 1'b1;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] CAUSE_NONE      = 3'd0;
   localparam logic [2:0] CAUSE_NO_COLON  = 3'd1;
   localparam logic [2:0] CAUSE_BAD_DIGIT = 3'd2;
   localparam logic [2:0] CAUSE_FULL      = 3'd3;
   localparam logic [2:0] CAUSE_TRUNCATED = 3'd4;

   localparam logic [CharWidth-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CharWidth-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CharWidth-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CharWidth-1:0] CHAR_SPACE = 8'h20;

   localparam logic [CharWidth-1:0] TYPE_DATA = 8'h00;
   localparam logic [CharWidth-1:0] TYPE_EOF  = 8'h01;

   localparam logic [CountWidth-1:0] BYTE_LIMIT_RESET = 16'd8191;

   typedef struct packed {
      logic                 op;
      logic [CharWidth-1:0] char_in;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [CharWidth-1:0]  data_byte;
      logic [CountWidth-1:0] byte_total;
      logic [2:0]            error_cause;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } step_result_type;

   // Returns {digit_ok, nibble}; digit_ok is low for anything but 0-9, A-F, a-f.
   function automatic logic [4:0] hex_nibble(input logic [CharWidth-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// File: rtl/ihex_req_if.sv
// Valid/ready channel carrying one text character or end marker per beat.
interface ihex_req_if;
   logic                     valid;
   logic                     ready;
   ihex_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/ihex_rsp_if.sv
// Valid/ready channel carrying one decoded byte or status per beat.
interface ihex_rsp_if;
   logic                     valid;
   logic                     ready;
   ihex_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/ihex_core.sv
// Record parser state and the per-character step logic.
module ihex_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  ihex_pkg::req_payload_type           item,
   input  logic [ihex_pkg::CountWidth-1:0]     byte_limit,
   output ihex_pkg::step_result_type           result
);

   localparam logic [2:0] PH_BETWEEN = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_DATA    = 3'd2;
   localparam logic [2:0] PH_SKIP    = 3'd3;
   localparam logic [2:0] PH_CHECK   = 3'd4;
   localparam logic [2:0] PH_LINE    = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic        nibble_pending_ff, nibble_pending_in;
   logic [1:0]  header_index_ff, header_index_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [8:0]  chars_left_ff, chars_left_in;
   logic [ihex_pkg::CountWidth-1:0] bytes_emitted_ff, bytes_emitted_in;
   logic        halted_ff, halted_in;

   logic [4:0]  digit;
   logic [7:0]  full_byte;
   logic [ihex_pkg::CountWidth-1:0] bytes_plus_one;

   assign digit          = ihex_pkg::hex_nibble(item.char_in);
   assign full_byte      = {high_nibble_ff, digit[3:0]};
   assign bytes_plus_one = bytes_emitted_ff + 16'd1;

   always_comb begin
      phase_in          = phase_ff;
      high_nibble_in    = high_nibble_ff;
      nibble_pending_in = nibble_pending_ff;
      header_index_in   = header_index_ff;
      record_length_in  = record_length_ff;
      chars_left_in     = chars_left_ff;
      bytes_emitted_in  = bytes_emitted_ff;
      halted_in         = halted_ff;

      result                     = '0;
      result.payload.kind        = ihex_pkg::KIND_DATA;
      result.payload.error_cause = ihex_pkg::CAUSE_NONE;
      result.payload.byte_total  = bytes_emitted_ff;

      if (item.op == ihex_pkg::OP_END) begin
         if (!halted_ff) begin
            result.valid = 1'b1;
            if (phase_ff == PH_BETWEEN || phase_ff == PH_LINE) begin
               result.payload.kind = ihex_pkg::KIND_DONE;
            end else begin
               result.payload.kind        = ihex_pkg::KIND_ERROR;
               result.payload.error_cause = ihex_pkg::CAUSE_TRUNCATED;
            end
         end
         // The end beat always starts a fresh text.
         phase_in          = PH_BETWEEN;
         high_nibble_in    = 4'd0;
         nibble_pending_in = 1'b0;
         header_index_in   = 2'd0;
         record_length_in  = 8'd0;
         chars_left_in     = 9'd0;
         bytes_emitted_in  = '0;
         halted_in         = 1'b0;
      end else if (!halted_ff) begin
         case (phase_ff)
            PH_HEADER, PH_DATA: begin
               if (!digit[4]) begin
                  halted_in                  = 1'b1;
                  result.valid               = 1'b1;
                  result.payload.kind        = ihex_pkg::KIND_ERROR;
                  result.payload.error_cause = ihex_pkg::CAUSE_BAD_DIGIT;
               end else if (!nibble_pending_ff) begin
                  high_nibble_in    = digit[3:0];
                  nibble_pending_in = 1'b1;
               end else if (phase_ff == PH_HEADER) begin
                  nibble_pending_in = 1'b0;
                  header_index_in   = header_index_ff + 2'd1;
                  if (header_index_ff == 2'd0) begin
                     record_length_in = full_byte;
                  end else if (header_index_ff == 2'd3) begin
                     if (full_byte == ihex_pkg::TYPE_EOF) begin
                        halted_in           = 1'b1;
                        result.valid        = 1'b1;
                        result.payload.kind = ihex_pkg::KIND_DONE;
                     end else if (record_length_ff == 8'd0) begin
                        phase_in      = PH_CHECK;
                        chars_left_in = 9'd2;
                     end else if (full_byte == ihex_pkg::TYPE_DATA) begin
                        phase_in      = PH_DATA;
                        chars_left_in = {1'b0, record_length_ff};
                     end else begin
                        phase_in      = PH_SKIP;
                        chars_left_in = {record_length_ff, 1'b0};
                     end
                  end
               end else begin
                  nibble_pending_in = 1'b0;
                  result.valid      = 1'b1;
                  if (bytes_emitted_ff >= byte_limit) begin
                     halted_in                  = 1'b1;
                     result.payload.kind        = ihex_pkg::KIND_ERROR;
                     result.payload.error_cause = ihex_pkg::CAUSE_FULL;
                  end else begin
                     bytes_emitted_in          = bytes_plus_one;
                     result.payload.data_byte  = full_byte;
                     result.payload.byte_total = bytes_plus_one;
                     if (chars_left_ff < 9'd2) begin
                        phase_in      = PH_CHECK;
                        chars_left_in = 9'd2;
                     end else begin
                        chars_left_in = chars_left_ff - 9'd1;
                     end
                  end
               end
            end
            PH_SKIP: begin
               if (chars_left_ff < 9'd2) begin
                  phase_in      = PH_CHECK;
                  chars_left_in = 9'd2;
               end else begin
                  chars_left_in = chars_left_ff - 9'd1;
               end
            end
            PH_CHECK: begin
               if (chars_left_ff < 9'd2) begin
                  phase_in      = PH_LINE;
                  chars_left_in = 9'd0;
               end else begin
                  chars_left_in = chars_left_ff - 9'd1;
               end
            end
            PH_LINE: begin
               if (item.char_in == ihex_pkg::CHAR_LF) begin
                  phase_in = PH_BETWEEN;
               end
            end
            default: begin
               if (item.char_in == ihex_pkg::CHAR_COLON) begin
                  phase_in          = PH_HEADER;
                  header_index_in   = 2'd0;
                  nibble_pending_in = 1'b0;
               end else if (item.char_in != ihex_pkg::CHAR_CR &&
                            item.char_in != ihex_pkg::CHAR_LF &&
                            item.char_in != ihex_pkg::CHAR_SPACE) begin
                  halted_in                  = 1'b1;
                  result.valid               = 1'b1;
                  result.payload.kind        = ihex_pkg::KIND_ERROR;
                  result.payload.error_cause = ihex_pkg::CAUSE_NO_COLON;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_BETWEEN;
         high_nibble_ff    <= 4'd0;
         nibble_pending_ff <= 1'b0;
         header_index_ff   <= 2'd0;
         record_length_ff  <= 8'd0;
         chars_left_ff     <= 9'd0;
         bytes_emitted_ff  <= '0;
         halted_ff         <= 1'b0;
      end else if (step_en) begin
         phase_ff          <= phase_in;
         high_nibble_ff    <= high_nibble_in;
         nibble_pending_ff <= nibble_pending_in;
         header_index_ff   <= header_index_in;
         record_length_ff  <= record_length_in;
         chars_left_ff     <= chars_left_in;
         bytes_emitted_ff  <= bytes_emitted_in;
         halted_ff         <= halted_in;
      end
   end

endmodule

// File: rtl/intel_hex_record_decoder_top.sv
// Top level of the streaming HEX record decoder: input stage, parser, result stage.
//
//   channel   direction   beat contents
//   req_bus   in          op, char_in
//   rsp_bus   out         kind, data_byte, byte_total, error_cause
//   csr_*     in          byte_limit write (16 bits)
//
// One character per cycle sustained unless a result stalls; an item is held in the input
// register and its result, if any, is loaded into the result register when it advances.
// Reset is synchronous and restores byte_limit to 8191 and the parser to between records.
// A full result register that is not taken stalls only items that produce a result;
// the input register still accepts a beat whenever it is empty or draining.
module intel_hex_record_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   ihex_req_if.sink                        req_bus,
   ihex_rsp_if.source                      rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [ihex_pkg::CountWidth-1:0] csr_write_data
);

   logic                      in_valid_ff, in_valid_in;
   ihex_pkg::req_payload_type in_item_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   ihex_pkg::rsp_payload_type rsp_payload_ff;
   logic [ihex_pkg::CountWidth-1:0] byte_limit_ff;

   ihex_pkg::step_result_type step_result;
   logic                      out_free;
   logic                      advance;
   logic                      load_rsp;
   logic                      req_fire;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = in_valid_ff && (!step_result.valid || out_free);
   assign load_rsp = advance && step_result.valid;
   assign req_fire = req_bus.valid && req_bus.ready;

   assign req_bus.ready   = !in_valid_ff || advance;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   ihex_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .item       (in_item_ff),
      .byte_limit (byte_limit_ff),
      .result     (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_limit_ff <= ihex_pkg::BYTE_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            byte_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_bus.payload;
      end
      if (load_rsp) begin
         rsp_payload_ff <= step_result.payload;
      end
   end

   // A data beat always counts itself and never passes the configured limit.
   a_data_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.kind == ihex_pkg::KIND_DATA) |->
         (rsp_payload_ff.byte_total != '0 && rsp_payload_ff.byte_total <= byte_limit_ff))
      else $error("data beat total out of range");

   // Only error beats carry a cause, and every error beat has one.
   a_cause_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_payload_ff.kind == ihex_pkg::KIND_ERROR) ==
          (rsp_payload_ff.error_cause != ihex_pkg::CAUSE_NONE)))
      else $error("error cause does not match kind");

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !load_rsp)
      else $error("result register overwritten");

   // A loaded result is presented on the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule
